>>> rtl/core/round_robin_task_scheduler_unit_assert.svh
// Assertion macros for the round-robin task scheduler.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

  localparam int SLOT_BITS       = 4;
  localparam int CMD_BITS        = 3;
  localparam int OUT_ID_BITS     = 16;
  localparam int MAX_TABLE_SLOTS = 1 << SLOT_BITS;
  localparam int DEF_TASK_SLOTS  = 16;
  localparam int DEF_ID_BITS     = 16;

  typedef logic [CMD_BITS-1:0]    cmd_t;
  typedef logic [SLOT_BITS-1:0]   slot_t;
  typedef logic [OUT_ID_BITS-1:0] out_id_t;
  typedef logic [1:0]             member_t;

  localparam cmd_t CMD_ADD       = 3'd0;
  localparam cmd_t CMD_MAKE_WAIT = 3'd1;
  localparam cmd_t CMD_MAKE_RDY  = 3'd2;
  localparam cmd_t CMD_REMOVE    = 3'd3;
  localparam cmd_t CMD_TICK      = 3'd4;

  localparam member_t MEM_NONE  = 2'd0;
  localparam member_t MEM_READY = 2'd1;
  localparam member_t MEM_WAIT  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/rrts_if.sv
// Command and result channel interfaces of the round-robin task scheduler.
`default_nettype none

interface rrts_cmd_if;
  import rrts_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  slot_t task_slot;
  logic  task_blocked;

  modport source(output valid, command, task_slot, task_blocked, input ready);
  modport sink(input valid, command, task_slot, task_blocked, output ready);
endinterface

interface rrts_res_if;
  import rrts_pkg::*;

  logic    valid;
  logic    ready;
  out_id_t assigned_id;
  slot_t   running_slot;
  logic    running_valid;
  logic    running_is_idle;
  logic    status;

  modport source(output valid, assigned_id, running_slot, running_valid, running_is_idle,
                 status, input ready);
  modport sink(input valid, assigned_id, running_slot, running_valid, running_is_idle,
               status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/round_robin_task_scheduler_unit.sv
// Round-robin task scheduler: ready and waiting queues as linked lists over slot tables.
// Accepts one command per cycle while the result side does not stall, and returns one
// result per command through one input register and one result register. Throughput
// is set by the link-table update between those registers; while a result waits to be
// taken, the input register can hold one more command. Link tables hold no reset value.
`default_nettype none

module round_robin_task_scheduler_unit #(
  parameter int TASK_SLOTS = rrts_pkg::DEF_TASK_SLOTS,
  parameter int ID_BITS    = rrts_pkg::DEF_ID_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  rrts_pkg::slot_t cfg_wr_data,
  rrts_cmd_if.sink        in_cmd,
  rrts_res_if.source      out_res
);
  import rrts_pkg::*;

  // Only slots reachable by the 4-bit slot field get table entries.
  localparam int DEPTH = (TASK_SLOTS < MAX_TABLE_SLOTS) ? TASK_SLOTS : MAX_TABLE_SLOTS;
  localparam int IW    = $clog2(DEPTH);

  typedef logic [IW-1:0] idx_t;

  slot_t idle_slot_r;

  logic  in_v_r;
  cmd_t  cmd_r;
  slot_t slot_r;
  logic  blocked_r;

  logic    out_v_r;
  out_id_t out_id_r;
  slot_t   out_slot_r;
  logic    out_rv_r;
  logic    out_idle_r;
  logic    out_status_r;

  idx_t    next_link_r [DEPTH];
  idx_t    prev_link_r [DEPTH];
  member_t member_r    [DEPTH];
  idx_t    next_link_nxt [DEPTH];
  idx_t    prev_link_nxt [DEPTH];
  member_t member_nxt    [DEPTH];

  idx_t rdy_head_r, rdy_tail_r, wt_head_r, wt_tail_r;
  logic rdy_ne_r, wt_ne_r;
  idx_t rdy_head_nxt, rdy_tail_nxt, wt_head_nxt, wt_tail_nxt;
  logic rdy_ne_nxt, wt_ne_nxt;

  slot_t              cur_slot_r, cur_slot_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;

  logic    fire;
  logic    slot_in_range, cur_in;
  idx_t    s, c, rd_addr;
  idx_t    nl_rd, pl_rd;
  member_t mem_rd;
  logic    do_unlink, unlink_wait, do_append, append_wait;
  logic    u_is_head, u_is_tail;
  idx_t    a_tail;
  logic    a_ne;
  logic    status_c;
  out_id_t id_out_c;

  assign fire         = in_v_r && (!out_v_r || out_res.ready);
  assign in_cmd.ready = !in_v_r || fire;

  assign slot_in_range = 32'(slot_r) < TASK_SLOTS;
  assign s             = slot_in_range ? idx_t'(slot_r) : '0;
  assign cur_in        = 32'(cur_slot_r) < TASK_SLOTS;
  assign c             = cur_in ? idx_t'(cur_slot_r) : '0;
  assign rd_addr       = (cmd_r == CMD_TICK) ? c : s;

  assign nl_rd  = next_link_r[rd_addr];
  assign pl_rd  = prev_link_r[s];
  assign mem_rd = member_r[rd_addr];

  assign u_is_head = s == (unlink_wait ? wt_head_r : rdy_head_r);
  assign u_is_tail = s == (unlink_wait ? wt_tail_r : rdy_tail_r);
  assign a_tail    = append_wait ? wt_tail_r : rdy_tail_r;
  assign a_ne      = append_wait ? wt_ne_r : rdy_ne_r;

  always_comb begin
    do_unlink   = 1'b0;
    unlink_wait = 1'b0;
    do_append   = 1'b0;
    append_wait = 1'b0;
    status_c    = 1'b0;
    id_out_c    = '0;
    id_nxt      = id_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    case (cmd_r)
      CMD_ADD: begin
        if (!slot_in_range || mem_rd != MEM_NONE) begin
          status_c = 1'b1;
        end else begin
          do_append = 1'b1;
          id_out_c  = OUT_ID_BITS'(id_r);
          id_nxt    = id_r + 1'b1;
        end
      end
      CMD_MAKE_WAIT: begin
        if (!slot_in_range || mem_rd != MEM_READY) begin
          status_c = 1'b1;
        end else begin
          do_unlink   = 1'b1;
          do_append   = 1'b1;
          append_wait = 1'b1;
        end
      end
      CMD_MAKE_RDY: begin
        if (!slot_in_range || mem_rd != MEM_WAIT) begin
          status_c = 1'b1;
        end else begin
          do_unlink   = 1'b1;
          unlink_wait = 1'b1;
        end
        do_append = !status_c;
      end
      CMD_REMOVE: begin
        if (!slot_in_range || mem_rd != (blocked_r ? MEM_WAIT : MEM_READY)) begin
          status_c = 1'b1;
        end else begin
          do_unlink   = 1'b1;
          unlink_wait = blocked_r;
          if (cur_valid_r && cur_slot_r == slot_r) begin
            cur_valid_nxt = 1'b0;
            cur_slot_nxt  = '0;
          end
        end
      end
      CMD_TICK: begin
        if (!cur_valid_r || !rdy_ne_r) begin
          cur_slot_nxt = idle_slot_r;
        end else if (cur_in && mem_rd == MEM_READY && c != rdy_tail_r) begin
          cur_slot_nxt = SLOT_BITS'(nl_rd);
        end else begin
          cur_slot_nxt = SLOT_BITS'(rdy_head_r);
        end
        cur_valid_nxt = 1'b1;
      end
      default: begin
        status_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    next_link_nxt = next_link_r;
    prev_link_nxt = prev_link_r;
    member_nxt    = member_r;
    rdy_head_nxt  = rdy_head_r;
    rdy_tail_nxt  = rdy_tail_r;
    rdy_ne_nxt    = rdy_ne_r;
    wt_head_nxt   = wt_head_r;
    wt_tail_nxt   = wt_tail_r;
    wt_ne_nxt     = wt_ne_r;
    if (do_unlink) begin
      if (u_is_head && u_is_tail) begin
        if (unlink_wait) begin
          wt_ne_nxt = 1'b0;
        end else begin
          rdy_ne_nxt = 1'b0;
        end
      end else begin
        if (!u_is_head) begin
          next_link_nxt[pl_rd] = nl_rd;
        end else if (unlink_wait) begin
          wt_head_nxt = nl_rd;
        end else begin
          rdy_head_nxt = nl_rd;
        end
        if (!u_is_tail) begin
          prev_link_nxt[nl_rd] = pl_rd;
        end else if (unlink_wait) begin
          wt_tail_nxt = pl_rd;
        end else begin
          rdy_tail_nxt = pl_rd;
        end
      end
      member_nxt[s] = MEM_NONE;
    end
    if (do_append) begin
      next_link_nxt[s] = '0;
      prev_link_nxt[s] = a_tail;
      if (a_ne) begin
        next_link_nxt[a_tail] = s;
      end else if (append_wait) begin
        wt_head_nxt = s;
      end else begin
        rdy_head_nxt = s;
      end
      if (append_wait) begin
        wt_tail_nxt   = s;
        wt_ne_nxt     = 1'b1;
        member_nxt[s] = MEM_WAIT;
      end else begin
        rdy_tail_nxt  = s;
        rdy_ne_nxt    = 1'b1;
        member_nxt[s] = MEM_READY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_slot_r <= '0;
    end else if (cfg_wr_en) begin
      idle_slot_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_cmd.ready) begin
      in_v_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_cmd.valid && in_cmd.ready) begin
      cmd_r     <= in_cmd.command;
      slot_r    <= in_cmd.task_slot;
      blocked_r <= in_cmd.task_blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_link_r <= next_link_nxt;
      prev_link_r <= prev_link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_r    <= '{default: MEM_NONE};
      rdy_head_r  <= '0;
      rdy_tail_r  <= '0;
      rdy_ne_r    <= 1'b0;
      wt_head_r   <= '0;
      wt_tail_r   <= '0;
      wt_ne_r     <= 1'b0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      id_r        <= '0;
    end else if (fire) begin
      member_r    <= member_nxt;
      rdy_head_r  <= rdy_head_nxt;
      rdy_tail_r  <= rdy_tail_nxt;
      rdy_ne_r    <= rdy_ne_nxt;
      wt_head_r   <= wt_head_nxt;
      wt_tail_r   <= wt_tail_nxt;
      wt_ne_r     <= wt_ne_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      id_r        <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_id_r     <= id_out_c;
      out_slot_r   <= cur_valid_nxt ? cur_slot_nxt : '0;
      out_rv_r     <= cur_valid_nxt;
      out_idle_r   <= cur_valid_nxt && (cur_slot_nxt == idle_slot_r);
      out_status_r <= status_c;
    end
  end

  assign out_res.valid           = out_v_r;
  assign out_res.assigned_id     = out_id_r;
  assign out_res.running_slot    = out_slot_r;
  assign out_res.running_valid   = out_rv_r;
  assign out_res.running_is_idle = out_idle_r;
  assign out_res.status          = out_status_r;

`include "round_robin_task_scheduler_unit_assert.svh"

  `RRTS_ASSERT_SAME(a_stall_blocks_input, in_v_r && out_v_r && !out_res.ready, !in_cmd.ready, "input taken while both stages are full")
  `RRTS_ASSERT_NEXT(a_tick_runs_task, fire && cmd_r == CMD_TICK, cur_valid_r && out_rv_r, "tick left no running task")
  `RRTS_ASSERT_NEXT(a_reject_keeps_id, fire && status_c, $stable(id_r), "rejected command consumed an identifier")
  `RRTS_ASSERT_SAME(a_idle_implies_running, out_v_r && out_idle_r, out_rv_r, "idle flag set without a running task")

endmodule

`default_nettype wire

>>> bench/rrts_schedule_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the task scheduler: tracks queues, predicts and compares each result.
module rrts_schedule_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  rrts_pkg::slot_t cfg_wr_data,
  rrts_cmd_if             cmd_mon,
  rrts_res_if             res_mon,
  output int              fail_count,
  output int              pending_count
);
  import rrts_pkg::*;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_IGNORED = 1'b1;

  typedef struct packed {
    out_id_t assigned_id;
    slot_t   running_slot;
    logic    running_valid;
    logic    running_is_idle;
    logic    status;
  } sched_result_t;

  slot_t   nxt_tbl    [MAX_TABLE_SLOTS];
  slot_t   prv_tbl    [MAX_TABLE_SLOTS];
  member_t member_tbl [MAX_TABLE_SLOTS];
  slot_t   rdy_head, rdy_tail, wt_head, wt_tail;
  logic    rdy_nonempty, wt_nonempty;
  slot_t   run_slot;
  logic    run_valid;
  out_id_t id_next;
  slot_t   idle_copy;

  sched_result_t expected_results[$];

  function automatic void clear_state();
    for (int i = 0; i < MAX_TABLE_SLOTS; i++) begin
      nxt_tbl[i]    = '0;
      prv_tbl[i]    = '0;
      member_tbl[i] = MEM_NONE;
    end
    rdy_head     = '0;
    rdy_tail     = '0;
    wt_head      = '0;
    wt_tail      = '0;
    rdy_nonempty = 1'b0;
    wt_nonempty  = 1'b0;
    run_slot     = '0;
    run_valid    = 1'b0;
    id_next      = '0;
    idle_copy    = '0;
  endfunction

  function automatic void link_append(input logic to_wait, input slot_t s);
    slot_t head, tail;
    logic  nonempty;
    head     = to_wait ? wt_head : rdy_head;
    tail     = to_wait ? wt_tail : rdy_tail;
    nonempty = to_wait ? wt_nonempty : rdy_nonempty;
    nxt_tbl[s] = '0;
    prv_tbl[s] = tail;
    if (nonempty) begin
      nxt_tbl[tail] = s;
    end else begin
      head = s;
    end
    tail     = s;
    nonempty = 1'b1;
    if (to_wait) begin
      wt_head     = head;
      wt_tail     = tail;
      wt_nonempty = nonempty;
    end else begin
      rdy_head     = head;
      rdy_tail     = tail;
      rdy_nonempty = nonempty;
    end
    member_tbl[s] = to_wait ? MEM_WAIT : MEM_READY;
  endfunction

  function automatic void link_unlink(input logic from_wait, input slot_t s);
    slot_t head, tail, p, n;
    logic  nonempty;
    head     = from_wait ? wt_head : rdy_head;
    tail     = from_wait ? wt_tail : rdy_tail;
    nonempty = from_wait ? wt_nonempty : rdy_nonempty;
    p = prv_tbl[s];
    n = nxt_tbl[s];
    if (s == head && s == tail) begin
      nonempty = 1'b0;
    end else begin
      if (s == head) begin
        head = n;
      end else begin
        nxt_tbl[p] = n;
      end
      if (s == tail) begin
        tail = p;
      end else begin
        prv_tbl[n] = p;
      end
    end
    if (from_wait) begin
      wt_head     = head;
      wt_tail     = tail;
      wt_nonempty = nonempty;
    end else begin
      rdy_head     = head;
      rdy_tail     = tail;
      rdy_nonempty = nonempty;
    end
    member_tbl[s] = MEM_NONE;
  endfunction

  function automatic sched_result_t predict_command(input cmd_t c, input slot_t s,
                                                    input logic blk);
    sched_result_t r;
    r = '0;
    r.status = ST_DONE;
    case (c)
      CMD_ADD: begin
        if (member_tbl[s] != MEM_NONE) begin
          r.status = ST_IGNORED;
        end else begin
          link_append(1'b0, s);
          r.assigned_id = id_next;
          id_next = id_next + 1'b1;
        end
      end
      CMD_MAKE_WAIT: begin
        if (member_tbl[s] != MEM_READY) begin
          r.status = ST_IGNORED;
        end else begin
          link_unlink(1'b0, s);
          link_append(1'b1, s);
        end
      end
      CMD_MAKE_RDY: begin
        if (member_tbl[s] != MEM_WAIT) begin
          r.status = ST_IGNORED;
        end else begin
          link_unlink(1'b1, s);
          link_append(1'b0, s);
        end
      end
      CMD_REMOVE: begin
        if (member_tbl[s] != (blk ? MEM_WAIT : MEM_READY)) begin
          r.status = ST_IGNORED;
        end else begin
          link_unlink(blk, s);
          if (run_valid && run_slot == s) begin
            run_valid = 1'b0;
            run_slot  = '0;
          end
        end
      end
      CMD_TICK: begin
        if (!run_valid || !rdy_nonempty) begin
          run_slot = idle_copy;
        end else if (member_tbl[run_slot] == MEM_READY && run_slot != rdy_tail) begin
          run_slot = nxt_tbl[run_slot];
        end else begin
          run_slot = rdy_head;
        end
        run_valid = 1'b1;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.running_slot    = run_valid ? run_slot : '0;
    r.running_valid   = run_valid;
    r.running_is_idle = run_valid && run_slot == idle_copy;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        idle_copy = cfg_wr_data;
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("assigned_id", 32'(exp_r.assigned_id), 32'(res_mon.assigned_id));
          check_field("running_slot", 32'(exp_r.running_slot), 32'(res_mon.running_slot));
          check_field("running_valid", 32'(exp_r.running_valid),
                      32'(res_mon.running_valid));
          check_field("running_is_idle", 32'(exp_r.running_is_idle),
                      32'(res_mon.running_is_idle));
          check_field("status", 32'(exp_r.status), 32'(res_mon.status));
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_results.push_back(predict_command(cmd_mon.command, cmd_mon.task_slot,
                                                   cmd_mon.task_blocked));
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> bench/tb_round_robin_task_scheduler_unit.sv
`timescale 1ns / 1ps
// Top of the scheduler bench: clock, reset, command and result drivers, and verdict.
module tb_round_robin_task_scheduler_unit;
  import rrts_pkg::*;

  localparam int   CYCLE_LIMIT   = 800000;
  localparam int   LONG_HOLD     = 200;
  localparam int   DRAIN_CYCLES  = 2;
  localparam int   PHASES        = 7;
  localparam int   PHASE_ITEMS   = 200;
  localparam cmd_t CMD_BAD_FIRST = CMD_TICK + 3'd1;
  localparam cmd_t CMD_BAD_LAST  = '1;

  logic  clk;
  logic  rst_n;
  logic  cfg_wr_en;
  slot_t cfg_wr_data;
  int    fail_count;
  int    pending_count;
  int    cycle_count;
  bit    src_gaps;
  bit    sink_gaps;
  bit    hold_armed;
  bit    hold_done;

  rrts_cmd_if in_cmd ();
  rrts_res_if out_res ();

  round_robin_task_scheduler_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (in_cmd),
    .out_res     (out_res)
  );

  rrts_schedule_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_mon       (in_cmd),
    .res_mon       (out_res),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic issue(input cmd_t c, input slot_t s, input logic blk);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_cmd.valid        <= 1'b1;
    in_cmd.command      <= c;
    in_cmd.task_slot    <= s;
    in_cmd.task_blocked <= blk;
    @(posedge clk);
    while (!in_cmd.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_slot(input slot_t v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_command(input int pool_top);
    int   pick;
    cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c = CMD_ADD;
    end else if (pick < 40) begin
      c = CMD_MAKE_WAIT;
    end else if (pick < 55) begin
      c = CMD_MAKE_RDY;
    end else if (pick < 70) begin
      c = CMD_REMOVE;
    end else if (pick < 95) begin
      c = CMD_TICK;
    end else begin
      c = cmd_t'($urandom_range(int'(CMD_BAD_FIRST), int'(CMD_BAD_LAST)));
    end
    issue(c, slot_t'($urandom_range(0, pool_top)), logic'($urandom_range(0, 1)));
  endtask

  // result side: random ready gaps, plus one long hold-off to back up the pipeline
  initial begin : result_sink
    out_res.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int pool;
    rst_n               <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    in_cmd.valid        <= 1'b0;
    in_cmd.command      <= CMD_TICK;
    in_cmd.task_slot    <= '0;
    in_cmd.task_blocked <= 1'b0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle pick, adds, misfits, round-robin wrap, hand-over, removal of runner
    issue(CMD_TICK, 4'd0, 1'b0);
    issue(CMD_ADD, 4'd0, 1'b0);
    issue(CMD_ADD, 4'd15, 1'b1);
    issue(CMD_ADD, 4'd0, 1'b0);
    issue(CMD_MAKE_RDY, 4'd15, 1'b0);
    issue(CMD_MAKE_WAIT, 4'd3, 1'b0);
    issue(CMD_TICK, 4'd0, 1'b0);
    issue(CMD_TICK, 4'd0, 1'b0);
    issue(CMD_MAKE_WAIT, 4'd15, 1'b0);
    issue(CMD_TICK, 4'd15, 1'b1);
    issue(CMD_REMOVE, 4'd15, 1'b0);
    issue(CMD_REMOVE, 4'd15, 1'b1);
    issue(CMD_ADD, 4'd7, 1'b0);
    issue(CMD_MAKE_WAIT, 4'd0, 1'b0);
    issue(CMD_TICK, 4'd0, 1'b0);
    issue(CMD_REMOVE, 4'd7, 1'b0);
    issue(CMD_TICK, 4'd0, 1'b0);
    issue(CMD_BAD_FIRST, 4'd9, 1'b1);
    issue(CMD_BAD_FIRST + 3'd1, 4'd6, 1'b0);
    issue(CMD_BAD_LAST, 4'd15, 1'b1);
    issue(CMD_MAKE_RDY, 4'd0, 1'b0);
    issue(CMD_REMOVE, 4'd0, 1'b1);
    issue(CMD_REMOVE, 4'd0, 1'b0);
    set_idle_slot(4'd15);
    issue(CMD_TICK, 4'd0, 1'b0);

    // empty both queues back to back
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    for (int s = 0; s < MAX_TABLE_SLOTS; s++) begin
      issue(CMD_REMOVE, slot_t'(s), 1'b0);
      issue(CMD_REMOVE, slot_t'(s), 1'b1);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0 || ph == PHASES - 1) begin
        set_idle_slot(4'd15);
      end else if (ph == 1) begin
        set_idle_slot(4'd0);
      end else begin
        set_idle_slot(slot_t'($urandom_range(0, 15)));
      end
      src_gaps  = (ph != PHASES - 1);
      sink_gaps = (ph != PHASES - 1);
      if (ph == 2) begin
        hold_armed = 1'b1;
      end
      pool = 15;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          pool = (2 << $urandom_range(0, 3)) - 1;
        end
        random_command(pool);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_if.sv
rtl/core/round_robin_task_scheduler_unit.sv
bench/rrts_schedule_checker.sv
bench/tb_round_robin_task_scheduler_unit.sv
